### hw/rtl/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared types, action codes and table reset patterns for the buffer pool
// manager.
// ----------------------------------------------------------------------------
package pbm_pkg;

	localparam int POOL_BUFFERS_DEF = 128;
	localparam int BUFFER_BYTES_DEF = 64;
	localparam logic [7:0] NO_BUF = 8'hFF;

	// action codes
	localparam logic [2:0] ACT_ALLOC      = 3'd0;
	localparam logic [2:0] ACT_FREE       = 3'd1;
	localparam logic [2:0] ACT_FREE_CHAIN = 3'd2;
	localparam logic [2:0] ACT_STORE      = 3'd3;
	localparam logic [2:0] ACT_READ       = 3'd4;

	// table reset patterns
	localparam int TBL_NEXT = 0;
	localparam int TBL_PREV = 1;
	localparam int TBL_ZERO = 2;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] buffer_id;
		logic [5:0] byte_offset;
		logic [7:0] data_byte;
		logic       last_byte;
	} pbm_cmd_t;

	typedef struct packed {
		logic       status;
		logic [7:0] result_buffer;
		logic [7:0] read_byte;
		logic [6:0] fill_length;
		logic [7:0] next_link;
		logic [7:0] prev_link;
	} pbm_res_t;

	// value an entry holds after reset
	function automatic logic [7:0] tbl_init(int kind, int unsigned idx, int unsigned pool);
		logic [7:0] v;
		v = 8'h00;
		case (kind)
			TBL_NEXT: v = (idx == 0) ? NO_BUF : 8'(idx - 1);
			TBL_PREV: v = (idx + 1 >= pool) ? NO_BUF : 8'(idx + 1);
			default:  v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/packet_buffer_pool_manager.sv
// ----------------------------------------------------------------------------
// packet_buffer_pool_manager
// Pool of packet buffers on a doubly linked free list: allocate, free, free
// chain, byte-wise packet store into a growing chain, and read of a byte with its buffer's fill length and links.
// ----------------------------------------------------------------------------
//  channel  | ports              | handshake
//  command  | start, busy, cmd   | item taken when start high and busy low
//  result   | done, result       | one cycle strobe, no back-pressure
//
//  Store byte into a buffer with room: written in idle. Store needing a new
//  buffer: S_TAKE, S_LINK if a chain exists, S_BYTE. Allocate: S_TAKE. Read:
//  S_READ. Free: S_PUT1, S_PUT2. Free chain: both per buffer walked, set by
//  the read of the next link and the two writes to the prev-link RAM per
//  buffer. Pool exhaustion during a store walks the partial chain the same
//  way. Results appear in the cycle after the work ends. Reset is asynchronous;
//  link and length tables are valid at once through per-entry valid bits, so no clearing pass runs.
// ----------------------------------------------------------------------------
module packet_buffer_pool_manager
	import pbm_pkg::*;
#(
	parameter int POOL_BUFFERS = POOL_BUFFERS_DEF,
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pbm_cmd_t cmd,
	output logic     done,
	output pbm_res_t result
);

	localparam int AW  = $clog2(POOL_BUFFERS);
	localparam int FW  = $clog2(BUFFER_BYTES + 1);
	localparam int BAW = $clog2(POOL_BUFFERS * BUFFER_BYTES);

	localparam logic [1:0] K_ONE   = 2'd0;
	localparam logic [1:0] K_CHAIN = 2'd1;
	localparam logic [1:0] K_STORE = 2'd2;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_TAKE = 7'b0000010,
		S_LINK = 7'b0000100,
		S_BYTE = 7'b0001000,
		S_PUT1 = 7'b0010000,
		S_PUT2 = 7'b0100000,
		S_READ = 7'b1000000
	} state_t;

	state_t state_q, state_n;

	logic [7:0]    head_q, head_n;
	logic [7:0]    first_q, first_n;
	logic [7:0]    tail_q, tail_n;
	logic [FW-1:0] fill_q, fill_n;
	logic          drop_q, drop_n;
	logic [7:0]    buf_q, buf_n;
	logic [7:0]    nx_q, nx_n;
	logic [7:0]    old_q, old_n;
	logic [7:0]    steps_q, steps_n;
	logic [1:0]    kind_q, kind_n;
	logic          offok_q, offok_n;
	pbm_cmd_t      cmd_q, cmd_n;
	logic          done_q, done_n;
	pbm_res_t      res_q, res_n;

	logic [AW-1:0]  next_wa, next_ra, prev_wa, prev_ra, len_wa, len_ra;
	logic [7:0]     next_wd, next_rd, prev_wd, prev_rd;
	logic [FW-1:0]  len_wd, len_rd;
	logic           next_we, prev_we, len_we, byte_we;
	logic [BAW-1:0] byte_wa, byte_ra;
	logic [7:0]     byte_wd, byte_rd;

	pbm_cmd_t      cur;
	logic          do_byte;
	logic [7:0]    steps_inc;
	pbm_res_t      res_base;

	function automatic logic valid_id(logic [7:0] b);
		return b < 8'(POOL_BUFFERS);
	endfunction

	function automatic logic [BAW-1:0] baddr(logic [AW-1:0] idx, logic [7:0] off);
		return BAW'(idx) * BAW'(BUFFER_BYTES) + BAW'(off);
	endfunction

	// link, length and byte stores
	pbm_table #(.WIDTH(8), .DEPTH(POOL_BUFFERS), .KIND(TBL_NEXT)) u_next (
		.clk(clk), .arst_n(arst_n), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(next_ra), .rdata(next_rd)
	);

	pbm_table #(.WIDTH(8), .DEPTH(POOL_BUFFERS), .KIND(TBL_PREV)) u_prev (
		.clk(clk), .arst_n(arst_n), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(prev_ra), .rdata(prev_rd)
	);

	pbm_table #(.WIDTH(FW), .DEPTH(POOL_BUFFERS), .KIND(TBL_ZERO)) u_len (
		.clk(clk), .arst_n(arst_n), .we(len_we), .waddr(len_wa), .wdata(len_wd),
		.raddr(len_ra), .rdata(len_rd)
	);

	pbm_ram #(.WIDTH(8), .DEPTH(POOL_BUFFERS * BUFFER_BYTES)) u_bytes (
		.clk(clk), .we(byte_we), .waddr(byte_wa), .wdata(byte_wd),
		.raddr(byte_ra), .rdata(byte_rd)
	);

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	assign cur       = (state_q == S_IDLE) ? cmd : cmd_q;
	assign steps_inc = steps_q + 8'd1;

	always_comb begin
		res_base = '0;
		res_base.result_buffer = NO_BUF;
		res_base.next_link     = NO_BUF;
		res_base.prev_link     = NO_BUF;
	end

	// sequencer
	always_comb begin
		state_n = state_q;
		head_n  = head_q;
		first_n = first_q;
		tail_n  = tail_q;
		fill_n  = fill_q;
		drop_n  = drop_q;
		buf_n   = buf_q;
		nx_n    = nx_q;
		old_n   = old_q;
		steps_n = steps_q;
		kind_n  = kind_q;
		offok_n = offok_q;
		cmd_n   = cmd_q;
		done_n  = 1'b0;
		res_n   = res_q;
		do_byte = 1'b0;

		next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;
		prev_we = 1'b0; prev_wa = '0; prev_wd = '0; prev_ra = '0;
		len_we  = 1'b0; len_wa  = '0; len_wd  = '0; len_ra  = '0;
		byte_we = 1'b0; byte_wa = '0; byte_wd = '0; byte_ra = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_n = cmd;
					case (cmd.action)
						ACT_ALLOC: begin
							if (valid_id(head_q)) begin
								buf_n   = head_q;
								kind_n  = K_ONE;
								next_ra = AW'(head_q);
								state_n = S_TAKE;
							end else begin
								done_n = 1'b1;
								res_n  = res_base;
								res_n.status = 1'b1;
							end
						end
						ACT_FREE: begin
							if (valid_id(cmd.buffer_id)) begin
								buf_n   = cmd.buffer_id;
								kind_n  = K_ONE;
								state_n = S_PUT1;
							end else begin
								done_n = 1'b1;
								res_n  = res_base;
							end
						end
						ACT_FREE_CHAIN: begin
							if (valid_id(cmd.buffer_id)) begin
								buf_n   = cmd.buffer_id;
								kind_n  = K_CHAIN;
								steps_n = '0;
								next_ra = AW'(cmd.buffer_id);
								state_n = S_PUT1;
							end else begin
								done_n = 1'b1;
								res_n  = res_base;
							end
						end
						ACT_STORE: begin
							if (drop_q) begin
								if (cmd.last_byte) begin
									drop_n = 1'b0;
									done_n = 1'b1;
									res_n  = res_base;
									res_n.status = 1'b1;
								end
							end else if (valid_id(tail_q) && fill_q < FW'(BUFFER_BYTES)) begin
								do_byte = 1'b1;
							end else if (valid_id(head_q)) begin
								buf_n   = head_q;
								kind_n  = K_STORE;
								next_ra = AW'(head_q);
								state_n = S_TAKE;
							end else if (valid_id(first_q)) begin
								// pool exhausted: give back the partial chain
								buf_n   = first_q;
								kind_n  = K_STORE;
								steps_n = '0;
								next_ra = AW'(first_q);
								state_n = S_PUT1;
							end else begin
								first_n = NO_BUF;
								tail_n  = NO_BUF;
								fill_n  = '0;
								if (cmd.last_byte) begin
									done_n = 1'b1;
									res_n  = res_base;
									res_n.status = 1'b1;
								end else begin
									drop_n = 1'b1;
								end
							end
						end
						ACT_READ: begin
							if (valid_id(cmd.buffer_id)) begin
								next_ra = AW'(cmd.buffer_id);
								prev_ra = AW'(cmd.buffer_id);
								len_ra  = AW'(cmd.buffer_id);
								offok_n = 8'(cmd.byte_offset) < 8'(BUFFER_BYTES);
								if (offok_n) begin
									byte_ra = baddr(AW'(cmd.buffer_id), 8'(cmd.byte_offset));
								end
								state_n = S_READ;
							end else begin
								done_n = 1'b1;
								res_n  = res_base;
							end
						end
						default: ;
					endcase
				end
			end

			// unlink the free list head
			S_TAKE: begin
				if (valid_id(next_rd)) begin
					prev_we = 1'b1;
					prev_wa = AW'(next_rd);
					prev_wd = NO_BUF;
				end
				next_we = 1'b1;
				next_wa = AW'(buf_q);
				next_wd = NO_BUF;
				head_n  = next_rd;
				if (kind_q == K_ONE) begin
					done_n = 1'b1;
					res_n  = res_base;
					res_n.result_buffer = buf_q;
					state_n = S_IDLE;
				end else if (valid_id(first_q)) begin
					state_n = S_LINK;
				end else begin
					first_n = buf_q;
					tail_n  = buf_q;
					fill_n  = '0;
					state_n = S_BYTE;
				end
			end

			// append the new buffer to the chain
			S_LINK: begin
				prev_we = 1'b1;
				prev_wa = AW'(buf_q);
				prev_wd = tail_q;
				next_we = 1'b1;
				next_wa = AW'(tail_q);
				next_wd = buf_q;
				tail_n  = buf_q;
				fill_n  = '0;
				state_n = S_BYTE;
			end

			S_BYTE: begin
				do_byte = 1'b1;
			end

			// push buffer on the free list, first half
			S_PUT1: begin
				nx_n    = next_rd;
				next_we = 1'b1;
				next_wa = AW'(buf_q);
				next_wd = head_q;
				prev_we = 1'b1;
				prev_wa = AW'(buf_q);
				prev_wd = NO_BUF;
				len_we  = 1'b1;
				len_wa  = AW'(buf_q);
				len_wd  = '0;
				old_n   = head_q;
				head_n  = buf_q;
				state_n = S_PUT2;
			end

			// back link of the old head, then walk on
			S_PUT2: begin
				if (valid_id(old_q)) begin
					prev_we = 1'b1;
					prev_wa = AW'(old_q);
					prev_wd = buf_q;
				end
				if (kind_q != K_ONE && valid_id(nx_q) && steps_inc < 8'(POOL_BUFFERS)) begin
					buf_n   = nx_q;
					steps_n = steps_inc;
					next_ra = AW'(nx_q);
					state_n = S_PUT1;
				end else begin
					state_n = S_IDLE;
					res_n   = res_base;
					if (kind_q == K_STORE) begin
						first_n = NO_BUF;
						tail_n  = NO_BUF;
						fill_n  = '0;
						if (cmd_q.last_byte) begin
							done_n = 1'b1;
							res_n.status = 1'b1;
						end else begin
							drop_n = 1'b1;
						end
					end else begin
						done_n = 1'b1;
					end
				end
			end

			S_READ: begin
				done_n = 1'b1;
				res_n  = res_base;
				res_n.read_byte   = offok_q ? byte_rd : 8'h00;
				res_n.fill_length = 7'(len_rd);
				res_n.next_link   = next_rd;
				res_n.prev_link   = prev_rd;
				state_n = S_IDLE;
			end

			default: state_n = S_IDLE;
		endcase

		// byte write into the tail buffer
		if (do_byte) begin
			byte_we = 1'b1;
			byte_wa = baddr(AW'(tail_q), 8'(fill_q));
			byte_wd = cur.data_byte;
			len_we  = 1'b1;
			len_wa  = AW'(tail_q);
			len_wd  = fill_q + FW'(1);
			fill_n  = fill_q + FW'(1);
			state_n = S_IDLE;
			if (cur.last_byte) begin
				done_n  = 1'b1;
				res_n   = res_base;
				res_n.result_buffer = first_q;
				first_n = NO_BUF;
				tail_n  = NO_BUF;
				fill_n  = '0;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= 8'(POOL_BUFFERS - 1);
			first_q <= NO_BUF;
			tail_q  <= NO_BUF;
			fill_q  <= '0;
			drop_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			head_q  <= head_n;
			first_q <= first_n;
			tail_q  <= tail_n;
			fill_q  <= fill_n;
			drop_q  <= drop_n;
			done_q  <= done_n;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		buf_q   <= buf_n;
		nx_q    <= nx_n;
		old_q   <= old_n;
		steps_q <= steps_n;
		kind_q  <= kind_n;
		offok_q <= offok_n;
		cmd_q   <= cmd_n;
		res_q   <= res_n;
	end

endmodule

### hw/rtl/pbm_ram.sv
// ----------------------------------------------------------------------------
// pbm_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/pbm_table.sv
// ----------------------------------------------------------------------------
// pbm_table
// Per-buffer table held in RAM, with a valid bit per entry so that an entry
// never written since reset reads as its reset pattern.
// ----------------------------------------------------------------------------
module pbm_table
	import pbm_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int KIND  = TBL_ZERO,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [DEPTH-1:0] valid_q;
	logic             valid_s1;
	logic [AW-1:0]    raddr_s1;
	logic [WIDTH-1:0] ram_rdata;

	pbm_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// read side follows the ram latency
	always_ff @(posedge clk) begin
		raddr_s1 <= raddr;
		valid_s1 <= valid_q[raddr];
	end

	assign rdata = valid_s1 ? ram_rdata
		: WIDTH'(tbl_init(KIND, int'(raddr_s1), DEPTH));

endmodule
